@@ src/spq_pkg.sv @@
package spq_pkg;

  // operation codes carried in the func field
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned PriorityW = 16;
  localparam int unsigned CountOutW = 5;

  typedef struct packed {
    logic                        func;
    logic signed [ValueW-1:0]    item_value;
    logic        [PriorityW-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]    out_value;
    logic        [PriorityW-1:0] out_priority;
    logic                        out_valid;
    logic        [CountOutW-1:0] entry_count;
    logic                        push_rejected;
  } spq_out_t;

  // one stored entry
  typedef struct packed {
    logic signed [ValueW-1:0]    value;
    logic        [PriorityW-1:0] prio;
  } spq_entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       push;
    logic       pop;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage

@@ src/spq_in_if.sv @@
interface spq_in_if;
  logic             valid;
  logic             ready;
  spq_pkg::spq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/spq_out_if.sv @@
interface spq_out_if;
  logic              valid;
  logic              ready;
  spq_pkg::spq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/spq_cell.sv @@
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::spq_ctrl_t  ctrl_i,
  input  logic                occ_i,
  input  spq_pkg::spq_entry_t prev_entry_i,
  input  logic                prev_keep_i,
  input  spq_pkg::spq_entry_t next_entry_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic                keep_o
);

  spq_pkg::spq_entry_t entry_q, entry_d;

  // entry stays in place on a push when it ranks at or above the new one
  assign keep_o = occ_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (!keep_o) begin
        entry_d = prev_keep_i ? ctrl_i.new_entry : prev_entry_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ src/sorted_priority_queue.sv @@
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | func, item_value, item_priority
// out_o   | out | valid / ready | out_value, out_priority, out_valid, entry_count, push_rejected
//
// one item per cycle: each item updates the cell row, and
// its result sits in the output register on the next cycle
// the cell row compares every cell against the new priority in parallel
// reset clears the entry count and the output register; cells hold no reset
// in_i.ready drops only while a result waits in the output register and
// out_o.ready is low
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  spq_pkg::spq_out_t out_q, out_d;

  logic accept;
  logic is_push, is_pop;
  logic full, empty;
  logic push_ok, pop_ok;
  spq_pkg::spq_ctrl_t ctrl;

  // neighbor links, padded at both ends of the row
  spq_pkg::spq_entry_t link_entry [QUEUE_DEPTH+2];
  logic                link_keep  [QUEUE_DEPTH+1];

  // output register frees as soon as the sink takes the waiting result
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_push = (in_i.data.func == spq_pkg::FUNC_PUSH);
  assign is_pop  = (in_i.data.func == spq_pkg::FUNC_POP);
  assign full    = (count_q == CntW'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && is_pop && !empty;

  assign ctrl.push                     = push_ok;
  assign ctrl.pop                      = pop_ok;
  assign ctrl.new_entry.value          = in_i.data.item_value;
  assign ctrl.new_entry.prio           = in_i.data.item_priority;

  // virtual cell ahead of the head always "keeps", so the head can load new
  assign link_entry[0]             = '0;
  assign link_keep[0]              = 1'b1;
  assign link_entry[QUEUE_DEPTH+1] = '0;

  // cell 0 holds the highest priority; equal priorities in arrival order
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic occ;
    assign occ = (count_q > CntW'(i));

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .prev_entry_i (link_entry[i]),
      .prev_keep_i  (link_keep[i]),
      .next_entry_i (link_entry[i+2]),
      .entry_o      (link_entry[i+1]),
      .keep_o       (link_keep[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  // result of the accepted item; head entry is read before it shifts out
  always_comb begin
    out_d               = '0;
    out_d.out_value     = pop_ok ? link_entry[1].value : '0;
    out_d.out_priority  = pop_ok ? link_entry[1].prio : '0;
    out_d.out_valid     = pop_ok;
    out_d.entry_count   = spq_pkg::CountOutW'(count_d);
    out_d.push_rejected = accept && is_push && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // count never passes the row length
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // a pop on a non-empty queue yields a valid entry and one less held
  a_pop_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pop && !empty) |=>
      (out_q.out_valid && count_q == $past(count_q) - 1'b1))
    else $error("pop did not remove an entry");

  // a push on a full queue is rejected and leaves the count alone
  a_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_push && full) |=> (out_q.push_rejected && $stable(count_q)))
    else $error("push on full queue not rejected");

  // no new item while a result waits unclaimed
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result pending");

endmodule
